[sv/lpnab_pkg.sv]
// Shared types and constants of the length-prefixed NAL to start-code converter.
package lpnab_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned SIZE_W  = 20;
  localparam int unsigned NLS_W   = 3;
  localparam int unsigned PSL_W   = 11;
  localparam int unsigned ACC_W   = 32;
  localparam int unsigned QDEPTH  = 4;

  localparam logic [1:0] CFG_NAL_LENGTH_SIZE  = 2'd0;
  localparam logic [1:0] CFG_OUTPUT_CAPACITY  = 2'd1;
  localparam logic [1:0] CFG_PARAM_SET_LENGTH = 2'd2;

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_STOPPED = 2'd2;

  localparam logic [NLS_W-1:0]  NLS_DEFAULT = 3'd4;
  localparam logic [SIZE_W-1:0] CAP_RESET   = 20'h80000;
  localparam logic [BYTE_W-1:0] SC_ZERO     = 8'h00;
  localparam logic [BYTE_W-1:0] SC_ONE      = 8'h01;
  localparam logic [2:0]        SC_LEN      = 3'd4;

  // Effective settings seen by the front end.
  typedef struct packed {
    logic [NLS_W-1:0]  nls;
    logic [SIZE_W-1:0] cap;
    logic [PSL_W-1:0]  psl;
  } cfg_t;

  // One queued command: start code, data byte and/or end marker.
  typedef struct packed {
    logic              sc;
    logic              dat;
    logic              eop;
    logic [BYTE_W-1:0] data;
    logic [SIZE_W-1:0] plen;
  } cmd_t;

endpackage

[sv/lpnab_front.sv]
// Front end: parse length prefixes, track the sample and issue commands.
module lpnab_front import lpnab_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_t                cfg,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [BYTE_W-1:0]   in_data_byte,
  input  logic                in_sample_start,
  input  logic [SIZE_W-1:0]   in_sample_size,
  input  logic                in_is_sync,
  output logic                push,
  output cmd_t                cmd
);

  logic [SIZE_W-1:0] rem_r, rem_nxt, rem;
  logic [2:0]        hc_r, hc_nxt, hc, hc1;
  logic [ACC_W-1:0]  acc_r, acc_nxt, acc, len;
  logic [ACC_W-1:0]  pl_r, pl_nxt, pl;
  logic [1:0]        ph_r, ph_nxt, ph;
  logic [SIZE_W-1:0] cnt_r, cnt_nxt, cnt;
  logic [SIZE_W-1:0] rcap_r, rcap_nxt, rcap;
  logic [SIZE_W-1:0] cnt_init;
  logic              accept;

  assign accept = in_valid && !in_stall;

  always_comb begin
    cnt_init = '0;
    if (in_is_sync && cfg.psl != '0 && {9'b0, cfg.psl} < cfg.cap) begin
      cnt_init = {9'b0, cfg.psl};
    end
    rem  = in_sample_start ? in_sample_size : rem_r;
    hc   = in_sample_start ? 3'd0 : hc_r;
    acc  = in_sample_start ? '0 : acc_r;
    pl   = in_sample_start ? '0 : pl_r;
    ph   = in_sample_start ? PH_HEADER : ph_r;
    cnt  = in_sample_start ? cnt_init : cnt_r;
    rcap = in_sample_start ? cfg.cap - cnt_init : rcap_r;

    rem_nxt  = rem;
    hc_nxt   = hc;
    acc_nxt  = acc;
    pl_nxt   = pl;
    ph_nxt   = ph;
    cnt_nxt  = cnt;
    rcap_nxt = rcap;
    cmd      = '0;
    cmd.data = in_data_byte;
    len      = {acc[ACC_W-9:0], in_data_byte};
    hc1      = hc + 3'd1;

    if (rem != '0) begin
      unique case (ph)
        PH_HEADER: begin
          if (hc == 3'd0 && rem < {17'b0, cfg.nls}) begin
            ph_nxt = PH_STOPPED;
          end else if (hc1 >= cfg.nls) begin
            hc_nxt  = '0;
            acc_nxt = '0;
            // Stop when the NAL runs past the sample or past the capacity.
            if (len >= {12'b0, rem} ||
                ({1'b0, len} + 33'd4) > {13'b0, rcap}) begin
              ph_nxt = PH_STOPPED;
            end else begin
              cmd.sc   = 1'b1;
              cnt_nxt  = cnt + 20'd4;
              rcap_nxt = rcap - 20'd4;
              pl_nxt   = len;
              ph_nxt   = (len == '0) ? PH_HEADER : PH_PAYLOAD;
            end
          end else begin
            hc_nxt  = hc1;
            acc_nxt = len;
          end
        end
        PH_PAYLOAD: begin
          cmd.dat  = 1'b1;
          cnt_nxt  = cnt + 20'd1;
          rcap_nxt = rcap - 20'd1;
          pl_nxt   = pl - 32'd1;
          if (pl == 32'd1) begin
            ph_nxt = PH_HEADER;
          end
        end
        default: begin
        end
      endcase
      rem_nxt = rem - 20'd1;
      if (rem == 20'd1) begin
        cmd.eop  = 1'b1;
        cmd.plen = cnt_nxt;
      end
    end
  end

  assign push = accept && (cmd.sc || cmd.dat || cmd.eop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= '0;
      hc_r   <= '0;
      acc_r  <= '0;
      pl_r   <= '0;
      ph_r   <= PH_HEADER;
      cnt_r  <= '0;
      rcap_r <= '0;
    end else if (accept) begin
      rem_r  <= rem_nxt;
      hc_r   <= hc_nxt;
      acc_r  <= acc_nxt;
      pl_r   <= pl_nxt;
      ph_r   <= ph_nxt;
      cnt_r  <= cnt_nxt;
      rcap_r <= rcap_nxt;
    end
  end

endmodule

[sv/lpnab_queue.sv]
// Small command queue between the front end and the back end.
module lpnab_queue import lpnab_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t wr_cmd,
  input  logic pop,
  output cmd_t rd_cmd,
  output logic empty,
  output logic full
);

  localparam int unsigned PTR_W = $clog2(QDEPTH);
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  cmd_t             mem_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == CNT_W'(QDEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_cmd  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      cnt_r <= cnt_r + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

endmodule

[sv/lpnab_back.sv]
// Back end: expand each command into result items through an output register.
module lpnab_back import lpnab_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                head,
  input  logic                empty,
  output logic                pop,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [BYTE_W-1:0]   out_byte,
  output logic                out_byte_valid,
  output logic                out_end_of_packet,
  output logic [SIZE_W-1:0]   out_packet_length,
  output logic                out_run_last
);

  logic [2:0]        sub_r, sub_nxt, total, last_idx;
  logic              load, last;
  logic              valid_r;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic              bv_r, bv_nxt;
  logic              eop_r, eop_nxt;
  logic [SIZE_W-1:0] plen_r, plen_nxt;
  logic              rl_r;

  assign load = !valid_r || !out_stall;

  always_comb begin
    total    = (head.sc ? SC_LEN : 3'd0) + {2'b0, head.dat} + {2'b0, head.eop};
    last_idx = total - 3'd1;
    last     = (sub_r == last_idx);
    byte_nxt = '0;
    bv_nxt   = 1'b0;
    eop_nxt  = 1'b0;
    plen_nxt = '0;
    if (head.sc && sub_r < SC_LEN) begin
      byte_nxt = (sub_r == SC_LEN - 3'd1) ? SC_ONE : SC_ZERO;
      bv_nxt   = 1'b1;
    end else if (head.dat && sub_r == 3'd0) begin
      byte_nxt = head.data;
      bv_nxt   = 1'b1;
    end else begin
      eop_nxt  = 1'b1;
      plen_nxt = head.plen;
    end
    pop     = load && !empty && last;
    sub_nxt = sub_r;
    if (load && !empty) begin
      sub_nxt = last ? 3'd0 : sub_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sub_r   <= '0;
    end else begin
      sub_r <= sub_nxt;
      if (load) begin
        valid_r <= !empty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      byte_r <= byte_nxt;
      bv_r   <= bv_nxt;
      eop_r  <= eop_nxt;
      plen_r <= plen_nxt;
      rl_r   <= last;
    end
  end

  assign out_valid         = valid_r;
  assign out_byte          = byte_r;
  assign out_byte_valid    = bv_r;
  assign out_end_of_packet = eop_r;
  assign out_packet_length = plen_r;
  assign out_run_last      = rl_r;

endmodule

[sv/length_prefixed_nal_to_annexb.sv]
// Order: an accepted item is queued, then loaded into the output register and offered.
// Throughput: one result item per cycle while the output is not stalled; an input item is
//   taken every cycle while the four-entry command queue has room, so a byte that yields a
//   start code plus marker gives five result items and the input waits on the queue.
// Reset: synchronous, active low; clears sample tracking, queue and output valid, and
//   restores the registers to length size 0 (taken as 4), capacity 524288 and no parameter sets.
module length_prefixed_nal_to_annexb import lpnab_pkg::*; #(
  parameter int unsigned MAX_PACKET_BYTES = 524288
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [SIZE_W-1:0]   cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [BYTE_W-1:0]   in_data_byte,
  input  logic                in_sample_start,
  input  logic [SIZE_W-1:0]   in_sample_size,
  input  logic                in_is_sync,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [BYTE_W-1:0]   out_byte,
  output logic                out_byte_valid,
  output logic                out_end_of_packet,
  output logic [SIZE_W-1:0]   out_packet_length,
  output logic                out_run_last
);

  // Configuration registers, raw as written.
  logic [NLS_W-1:0]  nls_r;
  logic [SIZE_W-1:0] cap_r;
  logic [PSL_W-1:0]  psl_r;
  cfg_t              cfg;
  cmd_t              wr_cmd, head;
  logic              push, pop, empty, full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nls_r <= '0;
      cap_r <= CAP_RESET;
      psl_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NAL_LENGTH_SIZE:  nls_r <= cfg_data[NLS_W-1:0];
        CFG_OUTPUT_CAPACITY:  cap_r <= cfg_data;
        CFG_PARAM_SET_LENGTH: psl_r <= cfg_data[PSL_W-1:0];
        default: begin
          // Index beyond the register list: drop the write.
        end
      endcase
    end
  end

  // Map length sizes outside 1..4 to 4 and clip capacity at the packet limit.
  always_comb begin
    cfg.nls = (nls_r >= 3'd1 && nls_r <= 3'd4) ? nls_r : NLS_DEFAULT;
    cfg.cap = ({12'b0, cap_r} < 32'(MAX_PACKET_BYTES)) ? cap_r
                                                       : SIZE_W'(MAX_PACKET_BYTES);
    cfg.psl = psl_r;
  end

  // Hold the input whenever the command queue is full.
  assign in_stall = full;

  lpnab_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_sample_start (in_sample_start),
    .in_sample_size  (in_sample_size),
    .in_is_sync      (in_is_sync),
    .push            (push),
    .cmd             (wr_cmd)
  );

  lpnab_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_cmd (wr_cmd),
    .pop    (pop),
    .rd_cmd (head),
    .empty  (empty),
    .full   (full)
  );

  lpnab_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .empty             (empty),
    .pop               (pop),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_byte          (out_byte),
    .out_byte_valid    (out_byte_valid),
    .out_end_of_packet (out_end_of_packet),
    .out_packet_length (out_packet_length),
    .out_run_last      (out_run_last)
  );

endmodule

[sv/lpnab_checker.sv]
// Port-level checks of the converter, bound to the top level.
module lpnab_checker import lpnab_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic [BYTE_W-1:0] out_byte,
  input logic              out_byte_valid,
  input logic              out_end_of_packet,
  input logic [SIZE_W-1:0] out_packet_length,
  input logic              out_run_last
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) &&
      $stable(out_end_of_packet) && $stable(out_run_last))
    else $error("stalled result changed");

  a_marker_or_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_byte_valid != out_end_of_packet)
    else $error("result is neither data nor marker");

  a_marker_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_packet |-> out_run_last && out_byte == SC_ZERO)
    else $error("end marker not last of its run");

  a_data_no_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_valid |-> out_packet_length == '0)
    else $error("data result carries a packet length");

endmodule

bind length_prefixed_nal_to_annexb lpnab_checker u_lpnab_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_byte          (out_byte),
  .out_byte_valid    (out_byte_valid),
  .out_end_of_packet (out_end_of_packet),
  .out_packet_length (out_packet_length),
  .out_run_last      (out_run_last)
);
